FILE: hdl/fsd_pkg.sv
// Shared types, constants and register codes for the error-diffusion dither core.
package fsd_pkg;

    // Default sizing of the line store and of stored error words
    localparam int DEF_MAX_WIDTH = 2048;
    localparam int DEF_ERR_BITS  = 10;

    // Field and register widths
    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Frame limits and pixel levels
    localparam int HEIGHT_LIMIT = 4096;
    localparam int PIX_MAX      = 255;

    // Diffusion weights, in sixteenths
    localparam logic [3:0] W_RIGHT       = 4'd7;
    localparam logic [3:0] W_BELOW_LEFT  = 4'd3;
    localparam logic [3:0] W_BELOW       = 4'd5;
    localparam logic [3:0] W_BELOW_RIGHT = 4'd1;

    // Register reset values
    localparam logic [WIDTH_W-1:0]  RST_WIDTH     = 12'd640;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT    = 13'd480;
    localparam logic [PIX_W-1:0]    RST_THRESHOLD = 8'd128;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd2;

    // Register file contents as seen by the datapath
    typedef struct packed {
        logic [WIDTH_W-1:0]  image_width;
        logic [HEIGHT_W-1:0] image_height;
        logic [PIX_W-1:0]    threshold;
    } t_cfg;

endpackage

FILE: hdl/fsd_cfg_regs.sv
// Configuration register file: frame width, frame height and threshold.
module fsd_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [fsd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output fsd_pkg::t_cfg                  o_cfg
);
    import fsd_pkg::*;

    t_cfg r_cfg;

    // Register write; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= RST_WIDTH;
            r_cfg.image_height <= RST_HEIGHT;
            r_cfg.threshold    <= RST_THRESHOLD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH: begin
                    r_cfg.image_width <= i_cfg_data[WIDTH_W-1:0];
                end
                CFG_IMAGE_HEIGHT: begin
                    r_cfg.image_height <= i_cfg_data[HEIGHT_W-1:0];
                end
                CFG_THRESHOLD: begin
                    r_cfg.threshold <= i_cfg_data[PIX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/fsd_line_ram.sv
// Line store RAM: one write port, one read port with registered read data.
module fsd_line_ram #(
    parameter int DEPTH  = fsd_pkg::DEF_MAX_WIDTH,
    parameter int DATA_W = fsd_pkg::DEF_ERR_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/fsd_engine.sv
// Per-pixel dither step: error fetch, threshold, diffusion and frame position.
module fsd_engine #(
    parameter int MAX_WIDTH = fsd_pkg::DEF_MAX_WIDTH,
    parameter int ERR_BITS  = fsd_pkg::DEF_ERR_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  fsd_pkg::t_cfg             i_cfg,
    input  logic                      i_step,
    input  logic [fsd_pkg::PIX_W-1:0] i_grey,
    output logic [fsd_pkg::PIX_W-1:0] o_bw,
    output logic                      o_eof
);
    import fsd_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int FW    = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = ((CW > WIDTH_W) ? CW : WIDTH_W) + 1;
    localparam int E     = ERR_BITS;
    localparam int SW    = ERR_BITS + 2;

    localparam logic signed [SW-1:0] SAT_HI    = SW'((1 << (E - 1)) - 1);
    localparam logic signed [SW-1:0] SAT_LO    = ~SAT_HI;
    localparam logic signed [SW-1:0] PIX_MAX_S = SW'(PIX_MAX);

    // Frame position and diffusion carries
    logic [CW-1:0]         r_column;
    logic [ROW_W-1:0]      r_row;
    logic signed [E-1:0]   r_rc;
    logic signed [E-1:0]   r_pb;
    logic signed [E-1:0]   r_pbr;
    // Line store bookkeeping
    logic [FW-1:0]         r_fill;
    logic                  r_buf_valid;
    logic [CW-1:0]         r_buf_addr;
    logic signed [E-1:0]   r_buf_data;
    logic                  r_rd_ok;
    logic                  r_rd_fwd;
    logic signed [E-1:0]   r_fwd_data;

    logic [CMP_W-1:0]      w_ext;
    logic [CMP_W-1:0]      w_eff;
    logic [HEIGHT_W-1:0]   h_eff;
    logic                  last_col;
    logic                  last_row;
    logic [E-1:0]          ram_rdata;
    logic signed [E-1:0]   line_val;
    logic signed [SW-1:0]  v_sum;
    logic [PIX_W-1:0]      v8;
    logic                  white;
    logic signed [9:0]     err;
    logic signed [9:0]     p7;
    logic signed [9:0]     p3;
    logic signed [9:0]     p5;
    logic signed [9:0]     p1;
    logic signed [E-1:0]   w1_data;
    logic signed [E-1:0]   pb_upd;
    logic signed [E-1:0]   pbr_upd;
    logic signed [E-1:0]   n_rc;
    logic signed [E-1:0]   n_pb;
    logic signed [E-1:0]   n_pbr;
    logic [CW-1:0]         n_column;
    logic [ROW_W-1:0]      n_row;
    logic [FW-1:0]         fill_cand;
    logic [FW-1:0]         n_fill;
    logic                  mem_we;
    logic [CW-1:0]         mem_waddr;
    logic [E-1:0]          mem_wdata;

    // k * e / 16, rounded toward zero
    function automatic logic signed [9:0] part(input logic signed [9:0] e,
                                               input logic [3:0] k);
        logic signed [14:0] p;
        logic signed [14:0] q;
        p = $signed({{5{e[9]}}, e}) * $signed({11'b0, k});
        if (p[14]) begin
            p = p + 15'sd15;
        end
        q = p >>> 4;
        return q[9:0];
    endfunction

    // Clamp to the signed error word range
    function automatic logic signed [E-1:0] sat(input logic signed [SW-1:0] x);
        logic signed [SW-1:0] y;
        if (x > SAT_HI) begin
            y = SAT_HI;
        end else if (x < SAT_LO) begin
            y = SAT_LO;
        end else begin
            y = x;
        end
        return y[E-1:0];
    endfunction

    fsd_line_ram #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (E)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (i_step),
        .i_raddr (n_column),
        .o_rdata (ram_rdata)
    );

    // Effective frame size and edge flags
    always_comb begin
        w_ext = CMP_W'(i_cfg.image_width);
        priority if (w_ext == '0) begin
            w_eff = CMP_W'(1);
        end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        priority if (i_cfg.image_height == '0) begin
            h_eff = HEIGHT_W'(1);
        end else if (i_cfg.image_height > HEIGHT_W'(HEIGHT_LIMIT)) begin
            h_eff = HEIGHT_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = i_cfg.image_height;
        end
        last_col = CMP_W'(r_column) >= (w_eff - CMP_W'(1));
        last_row = HEIGHT_W'(r_row) >= (h_eff - HEIGHT_W'(1));
    end

    // Error for this column: held last-column word, then fill and bypass checks
    always_comb begin
        priority if (r_buf_valid && (r_buf_addr == r_column)) begin
            line_val = r_buf_data;
        end else if (!r_rd_ok) begin
            line_val = '0;
        end else if (r_rd_fwd) begin
            line_val = r_fwd_data;
        end else begin
            line_val = $signed(ram_rdata);
        end
    end

    // Adjust, clamp and threshold
    always_comb begin
        v_sum = $signed(SW'({1'b0, i_grey})) + SW'(r_rc) + SW'(line_val);
        priority if (v_sum[SW-1]) begin
            v8 = '0;
        end else if (v_sum > PIX_MAX_S) begin
            v8 = PIX_W'(PIX_MAX);
        end else begin
            v8 = v_sum[PIX_W-1:0];
        end
        white = v8 > i_cfg.threshold;
        if (white) begin
            err = $signed({2'b00, v8}) - 10'sd255;
        end else begin
            err = $signed({2'b00, v8});
        end
        p7 = part(err, W_RIGHT);
        p3 = part(err, W_BELOW_LEFT);
        p5 = part(err, W_BELOW);
        p1 = part(err, W_BELOW_RIGHT);
    end

    // Diffusion into carries and the next row
    always_comb begin
        if (last_row) begin
            w1_data = sat(SW'(r_pb));
            pb_upd  = sat(SW'(r_pbr));
            pbr_upd = '0;
        end else begin
            w1_data = sat(SW'(r_pb) + SW'(p3));
            pb_upd  = sat(SW'(r_pbr) + SW'(p5));
            pbr_upd = last_col ? '0 : sat(SW'(p1));
        end
        if (last_col) begin
            n_rc     = '0;
            n_pb     = '0;
            n_pbr    = '0;
            n_column = '0;
            n_row    = last_row ? '0 : r_row + ROW_W'(1);
            fill_cand = FW'(r_column) + FW'(1);
        end else begin
            n_rc     = sat(SW'(p7));
            n_pb     = pb_upd;
            n_pbr    = pbr_upd;
            n_column = r_column + CW'(1);
            n_row    = r_row;
            fill_cand = FW'(r_column);
        end
        n_fill = (fill_cand > r_fill) ? fill_cand : r_fill;
    end

    // RAM write: below-left word, or the held last-column word on column zero
    always_comb begin
        if (r_column != '0) begin
            mem_we    = i_step;
            mem_waddr = r_column - CW'(1);
            mem_wdata = w1_data;
        end else begin
            mem_we    = i_step && r_buf_valid;
            mem_waddr = r_buf_addr;
            mem_wdata = r_buf_data;
        end
    end

    // State update on each step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_row       <= '0;
            r_rc        <= '0;
            r_pb        <= '0;
            r_pbr       <= '0;
            r_fill      <= '0;
            r_buf_valid <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_rd_fwd    <= 1'b0;
        end else if (i_step) begin
            r_column    <= n_column;
            r_row       <= n_row;
            r_rc        <= n_rc;
            r_pb        <= n_pb;
            r_pbr       <= n_pbr;
            r_fill      <= n_fill;
            r_buf_valid <= last_col;
            r_rd_ok     <= FW'(n_column) < n_fill;
            r_rd_fwd    <= mem_we && (mem_waddr == n_column);
        end
    end

    // Payload side of the held word and the bypass
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_buf_addr <= r_column;
            r_buf_data <= pb_upd;
            r_fwd_data <= $signed(mem_wdata);
        end
    end

    assign o_bw  = white ? PIX_W'(PIX_MAX) : '0;
    assign o_eof = last_col && last_row;

endmodule

FILE: hdl/floyd_steinberg_dither_core.sv
// Top level of the Floyd-Steinberg error-diffusion dither core.
//
// Usage:
//   Grey pixels enter on i_grey_in with i_in_valid / o_in_ready, in raster
//   order. Each pixel gives one word on o_bw_out (0 or 255) with
//   o_end_of_frame set on the last pixel of the frame, under o_out_valid /
//   i_out_ready. Registers (width, height, threshold) are written on the
//   i_cfg_* channel, which is always ready; write them only while no pixel
//   is in flight.
//   A pixel accepted into the input register is processed when the output
//   register can take its word, and that word is then registered on the
//   output. Throughput is one pixel per clock while i_out_ready stays high;
//   the line store RAM is written at most once and read once per pixel.
//   Reset: registers return to 640 x 480, threshold 128; position and error
//   carries clear, and a fill count marks the line store empty, so pixels
//   are taken from the first cycle after reset with no clearing pass.
//   Stall: while the output word waits, one more pixel is held in the input
//   register; after that o_in_ready drops until i_out_ready returns.
module floyd_steinberg_dither_core #(
    parameter int MAX_WIDTH = fsd_pkg::DEF_MAX_WIDTH,
    parameter int ERR_BITS  = fsd_pkg::DEF_ERR_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [fsd_pkg::PIX_W-1:0]      i_grey_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [fsd_pkg::PIX_W-1:0]      o_bw_out,
    output logic                           o_end_of_frame,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fsd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fsd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fsd_pkg::*;

    t_cfg             cfg;
    logic             r_in_valid;
    logic [PIX_W-1:0] r_grey;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_bw;
    logic             r_eof;
    logic             step;
    logic [PIX_W-1:0] bw;
    logic             eof;

    fsd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fsd_engine #(
        .MAX_WIDTH (MAX_WIDTH),
        .ERR_BITS  (ERR_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (step),
        .i_grey  (r_grey),
        .o_bw    (bw),
        .o_eof   (eof)
    );

    // Process the held pixel whenever the output register can take its word
    assign step        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || step;
    assign o_cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_grey <= i_grey_in;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_bw  <= bw;
            r_eof <= eof;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_bw_out       = r_bw;
    assign o_end_of_frame = r_eof;

endmodule
